// ----- rtl/lik_pkg.sv -----
`default_nettype none
package lik_pkg;

  localparam int unsigned CordicStepsDef = 16;
  localparam logic signed [22:0] PiQ16 = 23'sd205887;
  localparam logic signed [15:0] RightAngleOut = 16'sd5760;

  typedef enum logic [1:0] {
    CfgCoxa   = 2'd0,
    CfgFemur  = 2'd1,
    CfgTibia  = 2'd2,
    CfgTarsus = 2'd3
  } cfg_idx_e;

  function automatic logic signed [22:0] atan_q16(input int unsigned i);
    logic signed [22:0] t;
    case (i)
      0: t = 23'sd51472;
      1: t = 23'sd30386;
      2: t = 23'sd16055;
      3: t = 23'sd8150;
      4: t = 23'sd4091;
      5: t = 23'sd2047;
      6: t = 23'sd1024;
      7: t = 23'sd512;
      8: t = 23'sd256;
      9: t = 23'sd128;
      10: t = 23'sd64;
      11: t = 23'sd32;
      12: t = 23'sd16;
      13: t = 23'sd8;
      14: t = 23'sd4;
      15: t = 23'sd2;
      16: t = 23'sd1;
      default: t = 23'sd0;
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/lik_isqrt.sv -----
`default_nettype none
// Pipelined restoring square root, one result bit per stage.
// Sideband rides along unchanged.
module lik_isqrt #(
  parameter int unsigned InW = 64,
  parameter int unsigned SbW = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  input  wire logic [InW-1:0]   rad_i,
  input  wire logic [SbW-1:0]   sb_i,
  output logic                  valid_o,
  output logic [InW/2-1:0]      root_o,
  output logic [SbW-1:0]        sb_o
);
  localparam int unsigned OutW = InW / 2;
  localparam int unsigned RemW = OutW + 2;

  logic [OutW:0]           vld_q;
  logic [InW-1:0]          rad_q  [OutW+1];
  logic [RemW-1:0]         rem_q  [OutW+1];
  logic [OutW-1:0]         res_q  [OutW+1];
  logic [SbW-1:0]          sb_q   [OutW+1];

  always_comb begin
    rad_q[0] = rad_i;
    rem_q[0] = '0;
    res_q[0] = '0;
    sb_q[0]  = sb_i;
    vld_q[0] = valid_i;
  end

  for (genvar s = 0; s < OutW; s++) begin : g_st
    logic [RemW-1:0] rem_sh;
    logic [RemW-1:0] trial;
    logic [RemW-1:0] rem_d;
    logic [OutW-1:0] res_d;
    always_comb begin
      rem_sh = {rem_q[s][RemW-3:0], rad_q[s][InW-1 -: 2]};
      trial  = {res_q[s], 2'b01};
      if (rem_sh >= trial) begin
        rem_d = rem_sh - trial;
        res_d = {res_q[s][OutW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        res_d = {res_q[s][OutW-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vld_q[s+1] <= 1'b0;
      else vld_q[s+1] <= vld_q[s];
    end
    always_ff @(posedge clk_i) begin
      rad_q[s+1] <= {rad_q[s][InW-3:0], 2'b00};
      rem_q[s+1] <= rem_d;
      res_q[s+1] <= res_d;
      sb_q[s+1]  <= sb_q[s];
    end
  end

  assign valid_o = vld_q[OutW];
  assign root_o  = res_q[OutW];
  assign sb_o    = sb_q[OutW];
endmodule
`default_nettype wire

// ----- rtl/lik_cordic.sv -----
`default_nettype none
// Pipelined CORDIC vectoring: angle of (x, y) in Q16 radians, one step per stage.
module lik_cordic #(
  parameter int unsigned Steps = 16,
  parameter int unsigned VW    = 40,
  parameter int unsigned SbW   = 8
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  valid_i,
  input  wire logic signed [VW-1:0]  x_i,
  input  wire logic signed [VW-1:0]  y_i,
  input  wire logic [SbW-1:0]        sb_i,
  output logic                       valid_o,
  output logic signed [22:0]         ang_o,
  output logic [SbW-1:0]             sb_o
);
  import lik_pkg::*;
  localparam int unsigned XW = VW + 2;

  logic                 vld_q [Steps+2];
  logic                 zr_q  [Steps+2];
  logic signed [XW-1:0] x_q   [Steps+2];
  logic signed [XW-1:0] y_q   [Steps+2];
  logic signed [22:0]   a_q   [Steps+2];
  logic [SbW-1:0]       sb_q  [Steps+2];

  always_comb begin
    vld_q[0] = valid_i;
    zr_q[0]  = (x_i == '0) && (y_i == '0);
    x_q[0]   = XW'(x_i);
    y_q[0]   = XW'(y_i);
    a_q[0]   = '0;
    sb_q[0]  = sb_i;
  end

  // pre-rotate the left half-plane by pi
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q[1] <= 1'b0;
    else vld_q[1] <= vld_q[0];
  end
  always_ff @(posedge clk_i) begin
    sb_q[1] <= sb_q[0];
    zr_q[1] <= zr_q[0];
    if (x_q[0] < 0) begin
      x_q[1] <= -x_q[0];
      y_q[1] <= -y_q[0];
      a_q[1] <= (y_q[0] >= 0) ? PiQ16 : -PiQ16;
    end else begin
      x_q[1] <= x_q[0];
      y_q[1] <= y_q[0];
      a_q[1] <= '0;
    end
  end

  for (genvar s = 0; s < Steps; s++) begin : g_st
    logic signed [XW-1:0] xs, ys;
    logic signed [22:0]   t;
    always_comb begin
      xs = x_q[s+1] >>> s;
      ys = y_q[s+1] >>> s;
      t  = atan_q16(s);
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vld_q[s+2] <= 1'b0;
      else vld_q[s+2] <= vld_q[s+1];
    end
    always_ff @(posedge clk_i) begin
      sb_q[s+2] <= sb_q[s+1];
      zr_q[s+2] <= zr_q[s+1];
      if (y_q[s+1] > 0) begin
        x_q[s+2] <= x_q[s+1] + ys;
        y_q[s+2] <= y_q[s+1] - xs;
        a_q[s+2] <= a_q[s+1] + t;
      end else begin
        x_q[s+2] <= x_q[s+1] - ys;
        y_q[s+2] <= y_q[s+1] + xs;
        a_q[s+2] <= a_q[s+1] - t;
      end
    end
  end

  assign valid_o = vld_q[Steps+1];
  // the zero vector has angle zero
  assign ang_o   = zr_q[Steps+1] ? '0 : a_q[Steps+1];
  assign sb_o    = sb_q[Steps+1];
endmodule
`default_nettype wire

// ----- rtl/lik_conv.sv -----
`default_nettype none
// Q16 radians to 1/64 degree: |r|*366848/6553600 rounded half away from zero.
// Multiply, then divide by reciprocal with a one-step correction.
module lik_conv (
  input  wire logic               clk_i,
  input  wire logic signed [23:0] rad_i,
  output logic signed [15:0]      deg_o
);
  localparam logic [42:0] Num = 43'd366848;
  localparam logic [42:0] Den = 43'd6553600;
  localparam logic [42:0] Rnd = 43'd3276800;
  // floor(2^40 / Den) + 1
  localparam logic [22:0] Recip = 23'd167773;

  logic        neg_q, neg2_q;
  logic [42:0] p_q;
  logic [23:0] q_q;
  logic [42:0] p2_q;

  logic [23:0] mag;
  logic [65:0] est;
  logic [23:0] qe;
  logic [42:0] rem;

  always_comb begin
    mag = rad_i[23] ? 24'(-rad_i) : rad_i;
  end

  always_ff @(posedge clk_i) begin
    neg_q <= rad_i[23];
    p_q   <= 43'(mag) * Num + Rnd;
  end

  always_comb begin
    est = p_q * Recip;
    qe  = 24'(est >> 40);
  end

  always_ff @(posedge clk_i) begin
    neg2_q <= neg_q;
    q_q    <= qe;
    p2_q   <= p_q;
  end

  always_comb begin
    rem = p2_q - 43'(q_q) * Den;
    if (rem[42]) deg_o = neg2_q ? 16'(-(q_q - 24'd1)) : 16'(q_q - 24'd1);
    else if (rem >= Den) deg_o = neg2_q ? 16'(-(q_q + 24'd1)) : 16'(q_q + 24'd1);
    else deg_o = neg2_q ? 16'(-q_q) : 16'(q_q);
  end
endmodule
`default_nettype wire

// ----- rtl/leg_inverse_kinematics_4dof.sv -----
`default_nettype none
// Leg inverse kinematics, fully pipelined: one item per cycle, no stall.
// Item path: squares, reach sqrt, geometry stages, area sqrt, CORDIC chains and
// degree conversion; the two square roots and the CORDIC chains dominate the delay.
// done_o pulses once per item; results are valid only in that cycle.
// Reset clears the pipeline valid bits and loads default link lengths.
module leg_inverse_kinematics_4dof #(
  parameter int unsigned CORDIC_STEPS = lik_pkg::CordicStepsDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [13:0] target_x_i,
  input  wire logic signed [13:0] target_y_i,
  input  wire logic signed [13:0] target_z_i,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_idx_i,
  input  wire logic [11:0]        cfg_data_i,
  output logic                    done_o,
  output logic signed [15:0]      coxa_angle_o,
  output logic signed [15:0]      femur_angle_o,
  output logic signed [15:0]      tibia_angle_o,
  output logic signed [15:0]      tarsus_angle_o,
  output logic                    unreachable_o
);
  import lik_pkg::*;

  logic [11:0] coxa_q, femur_q, tibia_q, tarsus_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coxa_q <= 12'd736; femur_q <= 12'd1120; tibia_q <= 12'd1088; tarsus_q <= 12'd1328;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgCoxa:   coxa_q   <= cfg_data_i;
        CfgFemur:  femur_q  <= cfg_data_i;
        CfgTibia:  tibia_q  <= cfg_data_i;
        CfgTarsus: tarsus_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // stage 1: squares
  logic               v1_q;
  logic signed [13:0] x1_q, y1_q, z1_q;
  logic [26:0]        xx_q, yy_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else v1_q <= start;
  end
  always_ff @(posedge clk_i) begin
    x1_q <= target_x_i; y1_q <= target_y_i; z1_q <= target_z_i;
    xx_q <= 27'(target_x_i * target_x_i);
    yy_q <= 27'(target_y_i * target_y_i);
  end

  // reach = isqrt((x^2+y^2)*64), radicand under 2^34
  localparam int unsigned SbA = 42;
  logic [33:0]     rad_a;
  logic [SbA-1:0]  sba_o;
  logic            va_o;
  logic [16:0]     reach;
  assign rad_a = {28'(xx_q) + 28'(yy_q), 6'd0};
  lik_isqrt #(.InW(34), .SbW(SbA)) u_reach (
    .clk_i, .rst_ni, .valid_i(v1_q),
    .rad_i(rad_a),
    .sb_i({x1_q, y1_q, z1_q}),
    .valid_o(va_o), .root_o(reach), .sb_o(sba_o)
  );

  // stage: dx, dz, a, b
  logic               v2_q;
  logic signed [13:0] x2_q, y2_q;
  logic signed [18:0] dx_q, dz_q;
  logic [15:0]        la_q, lb_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else v2_q <= va_o;
  end
  always_ff @(posedge clk_i) begin
    x2_q <= sba_o[41:28]; y2_q <= sba_o[27:14];
    dx_q <= 19'(signed'({2'b0, reach})) - 19'(signed'({1'b0, coxa_q, 3'd0}));
    dz_q <= 19'((18'(signed'(sba_o[13:0])) + 18'(signed'({1'b0, tarsus_q}))) * 8);
    la_q <= {1'b0, femur_q, 3'd0};
    lb_q <= {1'b0, tibia_q, 3'd0};
  end

  // stage: c2, hi, lo, a^2, b^2
  logic               v3_q;
  logic signed [13:0] x3_q, y3_q;
  logic signed [18:0] dx3_q, dz3_q;
  logic [36:0]        c2_q;
  logic [33:0]        hi_q, lo_q, aa_q, bb_q;
  logic               zl_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else v3_q <= v2_q;
  end
  always_ff @(posedge clk_i) begin
    x3_q <= x2_q; y3_q <= y2_q; dx3_q <= dx_q; dz3_q <= dz_q;
    c2_q <= 37'(dx_q * dx_q) + 37'(dz_q * dz_q);
    hi_q <= 34'((17'(la_q) + 17'(lb_q)) * (17'(la_q) + 17'(lb_q)));
    lo_q <= (la_q >= lb_q) ? 34'((la_q - lb_q) * (la_q - lb_q))
                           : 34'((lb_q - la_q) * (lb_q - la_q));
    aa_q <= 34'(la_q * la_q);
    bb_q <= 34'(lb_q * lb_q);
    zl_q <= (la_q == 16'd0) || (lb_q == 16'd0);
  end

  // stage: range check and area factors
  logic               v4_q, bad4_q;
  logic signed [13:0] x4_q, y4_q;
  logic signed [18:0] dx4_q, dz4_q;
  logic [36:0]        c24_q;
  logic [33:0]        aa4_q, bb4_q, f1_q, f2_q;
  logic               bad;
  assign bad = zl_q || (c2_q == 37'd0) || (c2_q > 37'(hi_q)) || (c2_q < 37'(lo_q));
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else v4_q <= v3_q;
  end
  always_ff @(posedge clk_i) begin
    x4_q <= x3_q; y4_q <= y3_q; dx4_q <= dx3_q; dz4_q <= dz3_q;
    c24_q <= c2_q; aa4_q <= aa_q; bb4_q <= bb_q; bad4_q <= bad;
    f1_q <= bad ? 34'd0 : 34'(c2_q - 37'(lo_q));
    f2_q <= bad ? 34'd0 : 34'(37'(hi_q) - c2_q);
  end

  // stage: product for area (split into two 17-bit partials)
  logic               v5_q, bad5_q;
  logic signed [13:0] x5_q, y5_q;
  logic signed [18:0] dx5_q, dz5_q;
  logic [36:0]        c25_q;
  logic [33:0]        aa5_q, bb5_q;
  logic [50:0]        pl_q, ph_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else v5_q <= v4_q;
  end
  always_ff @(posedge clk_i) begin
    x5_q <= x4_q; y5_q <= y4_q; dx5_q <= dx4_q; dz5_q <= dz4_q;
    c25_q <= c24_q; aa5_q <= aa4_q; bb5_q <= bb4_q; bad5_q <= bad4_q;
    pl_q <= 51'(f1_q * f2_q[16:0]);
    ph_q <= 51'(f1_q * f2_q[33:17]);
  end

  localparam int unsigned SbB = 1 + 28 + 38 + 38 + 38 + 38;
  logic [63:0]    hrad;
  logic [SbB-1:0] sbh_i, sbh_o;
  logic           vh_o;
  logic [31:0]    hroot;
  logic signed [37:0] xb, xc, dxe, dze;
  assign hrad = 64'(pl_q) + (64'(ph_q) << 17);
  assign xb = 38'(signed'({1'b0, aa5_q})) - 38'(signed'({1'b0, bb5_q}))
            + 38'(signed'({1'b0, c25_q}));
  assign xc = 38'(signed'({1'b0, aa5_q})) + 38'(signed'({1'b0, bb5_q}))
            - 38'(signed'({1'b0, c25_q}));
  assign dxe = 38'(dx5_q);
  assign dze = 38'(dz5_q);
  assign sbh_i = {bad5_q, x5_q, y5_q, xb, xc, dze, dxe};
  lik_isqrt #(.InW(64), .SbW(SbB)) u_area (
    .clk_i, .rst_ni, .valid_i(v5_q), .rad_i(hrad), .sb_i(sbh_i),
    .valid_o(vh_o), .root_o(hroot), .sb_o(sbh_o)
  );

  logic               bad_h;
  logic signed [37:0] hb, xbh, xch, dxh, dzh;
  logic signed [13:0] xh, yh;
  assign {bad_h, xh, yh, xbh, xch, dzh, dxh} = sbh_o;
  assign hb = 38'(signed'({1'b0, hroot}));

  localparam int unsigned SbC = 1;
  logic               vb, vc, vt, vx;
  logic signed [22:0] ab, ac, at, ax;
  logic [SbC-1:0]     bad_c, sb_nc1, sb_nc2, sb_nc3;
  assign bad_c = bad_h;

  lik_cordic #(.Steps(CORDIC_STEPS), .VW(38), .SbW(SbC)) u_atb (
    .clk_i, .rst_ni, .valid_i(vh_o), .x_i(xbh), .y_i(hb), .sb_i(bad_c),
    .valid_o(vb), .ang_o(ab), .sb_o(sb_nc1));
  lik_cordic #(.Steps(CORDIC_STEPS), .VW(38), .SbW(SbC)) u_atc (
    .clk_i, .rst_ni, .valid_i(vh_o), .x_i(xch), .y_i(hb), .sb_i(bad_c),
    .valid_o(vc), .ang_o(ac), .sb_o(sb_nc2));
  lik_cordic #(.Steps(CORDIC_STEPS), .VW(38), .SbW(SbC)) u_att (
    .clk_i, .rst_ni, .valid_i(vh_o), .x_i(dxh), .y_i(dzh), .sb_i(bad_c),
    .valid_o(vt), .ang_o(at), .sb_o(sb_nc3));
  logic [SbC-1:0] bad_x;
  lik_cordic #(.Steps(CORDIC_STEPS), .VW(38), .SbW(SbC)) u_atx (
    .clk_i, .rst_ni, .valid_i(vh_o), .x_i(38'(yh)), .y_i(38'(xh)), .sb_i(bad_c),
    .valid_o(vx), .ang_o(ax), .sb_o(bad_x));

  logic signed [15:0] dcx, dfm, dtb;
  logic               v6_q, v7_q, bad6_q, bad7_q;
  lik_conv u_cvx (.clk_i, .rad_i(24'(ax)), .deg_o(dcx));
  lik_conv u_cvf (.clk_i, .rad_i(24'(at) + 24'(ab)), .deg_o(dfm));
  lik_conv u_cvt (.clk_i, .rad_i(24'(ac)), .deg_o(dtb));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0; v7_q <= 1'b0;
    end else begin
      v6_q <= vx && vb && vc && vt; v7_q <= v6_q;
    end
  end
  always_ff @(posedge clk_i) begin
    bad6_q <= bad_x[0] | sb_nc1[0] & sb_nc2[0] & sb_nc3[0];
    bad7_q <= bad6_q;
  end

  logic signed [15:0] fem, tib;
  assign fem = RightAngleOut - dfm;
  assign tib = RightAngleOut - dtb;
  assign done_o         = v7_q;
  assign unreachable_o  = bad7_q;
  assign coxa_angle_o   = bad7_q ? 16'sd0 : dcx;
  assign femur_angle_o  = bad7_q ? 16'sd0 : fem;
  assign tibia_angle_o  = bad7_q ? 16'sd0 : tib;
  assign tarsus_angle_o = bad7_q ? 16'sd0 : 16'(-fem - tib);
endmodule
`default_nettype wire
